// ===== sv/modular_exponentiation_assert.svh =====
// Assertion macros used by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ME_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ME_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/modexp_pkg.sv =====
`default_nettype none

package modexp_pkg;

	// Status of the shared modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
`default_nettype none

// Modular exponentiation: power_residue = base ** exponent mod modulus.
// Input: drive base, exponent and modulus with start high; the transaction
// is taken at the clock edge where start is high and busy is low. Unless modulus
// is 0, busy stays high until the result is out and start is ignored meanwhile.
// Output: done is high for exactly one cycle with power_residue valid. The
// receiver cannot hold the result off; it must take it in that cycle.
// Sequencing: every modular multiply runs on one shared shift-and-add unit
// at one multiplier bit per cycle. A transaction needs one base reduction,
// one multiply per set exponent bit and one squaring per exponent bit below
// the top one. A zero exponent finishes after the base reduction alone, and
// a zero modulus finishes without the multiplier, with result 0.
// One transaction at a time; a new one may start the cycle done is high.
// Reset clears the sequencer and drops any transaction in flight.
module modular_exponentiation #(
	parameter int WORD_BITS = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] base,
	input  logic [WORD_BITS-1:0] exponent,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 done,
	output logic [WORD_BITS-1:0] power_residue
);
	import modexp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_SQR
	} state_t;

	state_t               state_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 go_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] res_q;

	mm_stat_t             mm_stat;
	logic [WORD_BITS-1:0] mm_x;
	logic [WORD_BITS-1:0] mm_y;
	logic [WORD_BITS-1:0] mm_p;
	logic [WORD_BITS-1:0] e_shr;

	assign e_shr = e_q >> 1;

	always_comb begin
		unique case (state_q)
			ST_RED: begin
				mm_x = WORD_BITS'(1);
				mm_y = sq_q;
			end
			ST_MUL: begin
				mm_x = acc_q;
				mm_y = sq_q;
			end
			default: begin
				mm_x = sq_q;
				mm_y = sq_q;
			end
		endcase
	end

	modexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.x      (mm_x),
		.y      (mm_y),
		.m      (m_q),
		.stat   (mm_stat),
		.product(mm_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			go_q    <= 1'b0;
			acc_q   <= '0;
			sq_q    <= '0;
			e_q     <= '0;
			m_q     <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						m_q   <= modulus;
						e_q   <= exponent;
						sq_q  <= base;
						acc_q <= (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
						if (modulus == '0) begin
							res_q  <= '0;
							done_q <= 1'b1;
						end else begin
							busy_q  <= 1'b1;
							go_q    <= 1'b1;
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_stat.done) begin
						sq_q <= mm_p;
						if (e_q == '0) begin
							res_q   <= acc_q;
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							go_q    <= 1'b1;
							state_q <= e_q[0] ? ST_MUL : ST_SQR;
						end
					end
				end
				ST_MUL: begin
					if (mm_stat.done) begin
						acc_q <= mm_p;
						// Skip the last squaring once no exponent bits remain.
						if (e_shr == '0) begin
							res_q   <= mm_p;
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							go_q    <= 1'b1;
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					if (mm_stat.done) begin
						sq_q    <= mm_p;
						e_q     <= e_shr;
						go_q    <= 1'b1;
						state_q <= e_shr[0] ? ST_MUL : ST_SQR;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign power_residue = res_q;

`include "modular_exponentiation_assert.svh"

	`ME_ASSERT_NOW(a_done_idle, done_q, !busy_q && state_q == ST_IDLE, "result while busy")
	`ME_ASSERT_NOW(a_res_range, done_q, res_q < m_q || m_q == '0, "result not reduced")
	`ME_ASSERT_NOW(a_mm_owned, mm_stat.busy || mm_stat.done, busy_q, "multiplier active when idle")
	`ME_ASSERT_NEXT(a_accept, start && !busy_q && modulus != '0, busy_q, "transaction not taken")

endmodule

`default_nettype wire

// ===== sv/modexp_mulmod.sv =====
`default_nettype none

// Interleaved shift-and-add modular multiplier: one bit of y per cycle,
// MSB first. Requires x <= m and m >= 1; the product comes out below m.
module modexp_mulmod #(
	parameter int WORD_BITS = 30
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [WORD_BITS-1:0]     x,
	input  logic [WORD_BITS-1:0]     y,
	input  logic [WORD_BITS-1:0]     m,
	output modexp_pkg::mm_stat_t     stat,
	output logic [WORD_BITS-1:0]     product
);
	import modexp_pkg::*;

	localparam int CntW = $clog2(WORD_BITS + 1);
	localparam int AccW = WORD_BITS + 2;

	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] m_q;
	logic [CntW-1:0]      cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [AccW-1:0] sum;
	logic [AccW-1:0] m1;
	logic [AccW-1:0] m2;
	logic [AccW-1:0] red;

	// 2r + x stays below 3m, so at most one of m or 2m comes off.
	always_comb begin
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (y_q[WORD_BITS-1] ? {2'b00, x_q} : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (run_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(WORD_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			r_q <= red[WORD_BITS-1:0];
			y_q <= {y_q[WORD_BITS-2:0], 1'b0};
		end else if (start) begin
			r_q <= '0;
			y_q <= y;
			x_q <= x;
			m_q <= m;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign product   = r_q;

endmodule

`default_nettype wire
